// ===== rtl/ldmi_pkg.sv =====
// Package for the linear-to-multidimensional index converter: widths, register codes, stage type.
package ldmi_pkg;

  localparam int MAX_DIMS = 4;
  localparam int POS_W    = 31;
  localparam int SIZE_W   = 16;
  localparam int CNT_W    = 3;
  localparam int REG_W    = 3;

  localparam logic [REG_W-1:0] REG_DIM_COUNT  = 3'd0;
  localparam logic [REG_W-1:0] REG_DIM_SIZE_0 = 3'd1;
  localparam logic [REG_W-1:0] REG_DIM_SIZE_1 = 3'd2;
  localparam logic [REG_W-1:0] REG_DIM_SIZE_2 = 3'd3;
  localparam logic [REG_W-1:0] REG_DIM_SIZE_3 = 3'd4;

  // One beat as it moves down the divider chain.
  typedef struct packed {
    logic                             valid;
    logic [POS_W-1:0]                 qd;
    logic [SIZE_W-1:0]                rem;
    logic [MAX_DIMS-1:0][SIZE_W-1:0]  digits;
  } stage_t;

endpackage

// ===== rtl/ldmi_cell.sv =====
// One restoring-division step: produces one quotient bit and passes the beat on.
module ldmi_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ldmi_pkg::stage_t             din,
  input  logic [ldmi_pkg::SIZE_W-1:0]  divisor,
  output ldmi_pkg::stage_t             dout
);

  logic [ldmi_pkg::SIZE_W:0]   rem_sh;
  logic [ldmi_pkg::SIZE_W:0]   diff;
  logic                        ge;
  ldmi_pkg::stage_t            stage_nxt;
  ldmi_pkg::stage_t            stage_r;

  always_comb begin
    rem_sh    = {din.rem, din.qd[ldmi_pkg::POS_W-1]};
    ge        = (rem_sh >= {1'b0, divisor});
    diff      = rem_sh - {1'b0, divisor};
    stage_nxt = din;
    stage_nxt.qd  = {din.qd[ldmi_pkg::POS_W-2:0], ge};
    stage_nxt.rem = ge ? diff[ldmi_pkg::SIZE_W-1:0] : rem_sh[ldmi_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.qd     <= stage_nxt.qd;
    stage_r.rem    <= stage_nxt.rem;
    stage_r.digits <= stage_nxt.digits;
  end

  assign dout = stage_r;

endmodule

// ===== rtl/ldmi_dim.sv =====
// Divider chain for one dimension: splits off one digit and passes the quotient on.
module ldmi_dim (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ldmi_pkg::stage_t             din,
  input  logic [ldmi_pkg::SIZE_W-1:0]  divisor,
  output ldmi_pkg::stage_t             dout
);

  ldmi_pkg::stage_t chain [ldmi_pkg::POS_W+1];

  always_comb begin
    chain[0]     = din;
    chain[0].rem = '0;
  end

  for (genvar i = 0; i < ldmi_pkg::POS_W; i++) begin : g_cell
    ldmi_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .din     (chain[i]),
      .divisor (divisor),
      .dout    (chain[i+1])
    );
  end

  // The remainder is this dimension's digit; it enters the digit list at the bottom.
  always_comb begin
    dout           = chain[ldmi_pkg::POS_W];
    dout.rem       = '0;
    dout.digits[0] = chain[ldmi_pkg::POS_W].rem;
    for (int j = 1; j < ldmi_pkg::MAX_DIMS; j++) begin
      dout.digits[j] = chain[ldmi_pkg::POS_W].digits[j-1];
    end
  end

endmodule

// ===== rtl/linear_to_multidim_index.sv =====
// Top level: converts a linear position into a one-based column-major index.
// Pipeline: 31 division steps per dimension for 4 dimensions, plus the output
// register; one position is accepted every cycle, so busy stays low. The receiver
// cannot stall and takes every beat.
// Synchronous active-low reset clears the pipeline valid bits and sets
// dim_count and all sizes to 1.
module linear_to_multidim_index (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ldmi_pkg::POS_W-1:0]   in_position,
  output logic                         out_valid,
  output logic [ldmi_pkg::SIZE_W-1:0]  out_index_0,
  output logic [ldmi_pkg::SIZE_W-1:0]  out_index_1,
  output logic [ldmi_pkg::SIZE_W-1:0]  out_index_2,
  output logic [ldmi_pkg::SIZE_W-1:0]  out_index_3,
  input  logic                         cfg_we,
  input  logic [ldmi_pkg::REG_W-1:0]   cfg_index,
  input  logic [ldmi_pkg::SIZE_W-1:0]  cfg_wdata
);

  logic [ldmi_pkg::CNT_W-1:0]                           dim_count_r;
  logic [ldmi_pkg::MAX_DIMS-1:0][ldmi_pkg::SIZE_W-1:0]  size_r;
  logic [ldmi_pkg::MAX_DIMS-1:0][ldmi_pkg::SIZE_W-1:0]  size_eff;
  logic [ldmi_pkg::CNT_W-1:0]                           cnt_eff;
  ldmi_pkg::stage_t                                     stg [ldmi_pkg::MAX_DIMS+1];
  logic                                                 out_valid_r;
  logic [ldmi_pkg::MAX_DIMS-1:0][ldmi_pkg::SIZE_W-1:0]  index_r;
  logic [ldmi_pkg::MAX_DIMS-1:0][ldmi_pkg::SIZE_W-1:0]  index_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= ldmi_pkg::CNT_W'(1);
      size_r      <= {ldmi_pkg::MAX_DIMS{ldmi_pkg::SIZE_W'(1)}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldmi_pkg::REG_DIM_COUNT:  dim_count_r <= cfg_wdata[ldmi_pkg::CNT_W-1:0];
        ldmi_pkg::REG_DIM_SIZE_0: size_r[0]   <= cfg_wdata;
        ldmi_pkg::REG_DIM_SIZE_1: size_r[1]   <= cfg_wdata;
        ldmi_pkg::REG_DIM_SIZE_2: size_r[2]   <= cfg_wdata;
        ldmi_pkg::REG_DIM_SIZE_3: size_r[3]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dim_count_r == '0) begin
      cnt_eff = ldmi_pkg::CNT_W'(1);
    end else if (dim_count_r > ldmi_pkg::CNT_W'(ldmi_pkg::MAX_DIMS)) begin
      cnt_eff = ldmi_pkg::CNT_W'(ldmi_pkg::MAX_DIMS);
    end else begin
      cnt_eff = dim_count_r;
    end
    for (int k = 0; k < ldmi_pkg::MAX_DIMS; k++) begin
      size_eff[k] = (size_r[k] == '0) ? ldmi_pkg::SIZE_W'(1) : size_r[k];
    end
  end

  always_comb begin
    stg[0].valid  = start && !busy;
    stg[0].qd     = in_position;
    stg[0].rem    = '0;
    stg[0].digits = '0;
  end

  // Peeling digits fastest dimension first also performs the wrap modulo the full product.
  for (genvar k = 0; k < ldmi_pkg::MAX_DIMS; k++) begin : g_dim
    ldmi_dim u_dim (
      .clk     (clk),
      .rst_n   (rst_n),
      .din     (stg[k]),
      .divisor (size_eff[k]),
      .dout    (stg[k+1])
    );
  end

  // Dimension 0 ends up in the top digit slot after all shifts.
  always_comb begin
    for (int k = 0; k < ldmi_pkg::MAX_DIMS; k++) begin
      if (ldmi_pkg::CNT_W'(k) < cnt_eff) begin
        index_nxt[k] = stg[ldmi_pkg::MAX_DIMS].digits[ldmi_pkg::MAX_DIMS-1-k]
                       + ldmi_pkg::SIZE_W'(1);
      end else begin
        index_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg[ldmi_pkg::MAX_DIMS].valid;
    end
    index_r <= index_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_index_0 = index_r[0];
  assign out_index_1 = index_r[1];
  assign out_index_2 = index_r[2];
  assign out_index_3 = index_r[3];

  a_first_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_index_0 != '0))
    else $error("first index is zero on a valid beat");

  a_first_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_index_0 <= size_eff[0]))
    else $error("first index exceeds its dimension size");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (cnt_eff < ldmi_pkg::CNT_W'(ldmi_pkg::MAX_DIMS))) |-> (out_index_3 == '0))
    else $error("unused last index is not zero");

  a_chain_out: assert property (@(posedge clk) disable iff (!rst_n)
    stg[ldmi_pkg::MAX_DIMS].valid |=> out_valid)
    else $error("beat lost at output register");

endmodule
